// ===== hdl/ierw_pkg.sv =====
package ierw_pkg;

    // Frame and header geometry.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int HDR_LEN         = 38;
    localparam int HDR_AW          = $clog2(HDR_LEN);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 48;

    // Header byte offsets (20-byte IPv4 header, no options).
    localparam logic [HDR_AW-1:0] POS_ETYPE_HI = HDR_AW'(12);
    localparam logic [HDR_AW-1:0] POS_ETYPE_LO = HDR_AW'(13);
    localparam logic [HDR_AW-1:0] POS_PROTO    = HDR_AW'(23);
    localparam logic [HDR_AW-1:0] POS_SIP0     = HDR_AW'(26);
    localparam logic [HDR_AW-1:0] POS_DIP0     = HDR_AW'(30);
    localparam logic [HDR_AW-1:0] POS_DIP1     = HDR_AW'(31);
    localparam logic [HDR_AW-1:0] POS_DIP2     = HDR_AW'(32);
    localparam logic [HDR_AW-1:0] POS_DIP3     = HDR_AW'(33);
    localparam logic [HDR_AW-1:0] POS_ICMP_TYP = HDR_AW'(34);
    localparam logic [HDR_AW-1:0] POS_CKS_HI   = HDR_AW'(36);
    localparam logic [HDR_AW-1:0] POS_CKS_LO   = HDR_AW'(37);
    localparam logic [HDR_AW-1:0] POS_LAST     = HDR_AW'(HDR_LEN - 1);
    localparam logic [HDR_AW-1:0] POS_SMAC0    = HDR_AW'(6);
    localparam logic [HDR_AW-1:0] POS_ETYPE0   = HDR_AW'(12);

    // Expected field values.
    localparam logic [7:0]  ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0]  PROTO_ICMP    = 8'h01;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
    localparam logic [7:0]  ICMP_ECHO_REP = 8'h00;
    localparam logic [15:0] CKS_ADJUST    = 16'h0800;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = CFG_IDX_W'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_RECV,
        ST_CKSUM,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } state_t;

    // Where each reply header byte comes from.
    typedef enum logic [2:0] {
        SRC_RAM,
        SRC_MAC,
        SRC_ZERO,
        SRC_CKS_HI,
        SRC_CKS_LO
    } src_kind_t;

    function automatic src_kind_t reply_kind(input logic [HDR_AW-1:0] k);
        src_kind_t r;
        if (k >= POS_SMAC0 && k < POS_ETYPE0) begin
            r = SRC_MAC;
        end else if (k == POS_ICMP_TYP) begin
            r = SRC_ZERO;
        end else if (k == POS_CKS_HI) begin
            r = SRC_CKS_HI;
        end else if (k == POS_CKS_LO) begin
            r = SRC_CKS_LO;
        end else begin
            r = SRC_RAM;
        end
        return r;
    endfunction

    // Header store address read for reply byte k: MACs and IPs swap places.
    function automatic logic [HDR_AW-1:0] reply_addr(input logic [HDR_AW-1:0] k);
        logic [HDR_AW-1:0] a;
        if (k < POS_SMAC0) begin
            a = k + POS_SMAC0;
        end else if (k >= POS_SIP0 && k < POS_DIP0) begin
            a = k + HDR_AW'(4);
        end else if (k >= POS_DIP0 && k < POS_ICMP_TYP) begin
            a = k - HDR_AW'(4);
        end else begin
            a = k;
        end
        return a;
    endfunction

endpackage

// ===== hdl/ierw_ram.sv =====
module ierw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 38
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/icmp_echo_reply_rewriter.sv =====
// ICMP echo reply rewriter.
// The s_axis channel carries a received Ethernet frame one byte per transfer,
// with s_axis_tlast on the last byte. The m_axis channel carries the reply
// frame. The cfg channel writes local_mac (index 0) and local_ip (index 1);
// other indexes are ignored. cfg_ready is always high.
// The first 38 bytes are kept in a small header RAM while a single byte
// comparator checks ethertype, IP protocol, destination IP and ICMP type as
// each byte arrives. On byte 37 of a matching echo request the sequencer
// runs one ones-complement checksum step and then, for each reply byte,
// reads the header RAM, loads the output register and sends, waiting on any
// receiver stall; input is not accepted during the 38-byte header burst.
// Header bytes before the burst go to the RAM as they arrive. After the
// burst the rest of the frame is forwarded through the single output register.
// A stalled receiver holds the output register, and no input is taken until
// it drains. Frames that fail a check or end early produce nothing.
// Reset (aresetn low, synchronous) clears the sequencer, the frame position,
// the output valid and both configuration registers; no RAM clear is needed.
module icmp_echo_reply_rewriter
    import ierw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] frame_byte
    input  logic                  s_axis_tlast,   // frame_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] reply_byte
    output logic                  m_axis_tlast,   // reply_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                fwd_reg, fwd_next;
    logic                ok_reg, ok_next;
    logic [HDR_AW-1:0]   k_reg, k_next;
    logic [15:0]         cks_reg, cks_next;
    logic                end37_reg, end37_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic [47:0]         local_mac_reg;
    logic [31:0]         local_ip_reg;

    logic                s_fire, m_fire;
    logic                in_header;
    logic                hdr_done;
    logic [HDR_AW-1:0]   hdr_pos;
    logic                ram_wr_en, ram_rd_en;
    logic [HDR_AW-1:0]   ram_rd_addr;
    logic [7:0]          ram_rd_data;
    logic                cmp_active;
    logic [7:0]          cmp_expect;
    logic [16:0]         cks_sum;
    logic [7:0]          mac_bytes [6];
    logic [2:0]          mac_idx;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign m_fire    = out_valid_reg && m_axis_tready;
    assign in_header = pos_reg < POS_W'(HDR_LEN);
    assign hdr_pos   = pos_reg[HDR_AW-1:0];
    assign hdr_done  = m_fire && (k_reg == POS_LAST);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign cfg_ready     = 1'b1;

    // Local MAC split into wire-order bytes.
    for (genvar i = 0; i < 6; i++) begin : g_mac
        assign mac_bytes[i] = local_mac_reg[8*(5-i) +: 8];
    end
    assign mac_idx = 3'(k_reg - POS_SMAC0);

    // Header store.
    ierw_ram #(
        .WIDTH (8),
        .DEPTH (HDR_LEN)
    ) u_hdr_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (hdr_pos),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Expected value for the byte comparator at the current header position.
    always_comb begin
        cmp_active = 1'b1;
        cmp_expect = 8'h00;
        case (hdr_pos)
            POS_ETYPE_HI: cmp_expect = ETYPE_IPV4_HI;
            POS_ETYPE_LO: cmp_expect = ETYPE_IPV4_LO;
            POS_PROTO:    cmp_expect = PROTO_ICMP;
            POS_DIP0:     cmp_expect = local_ip_reg[31:24];
            POS_DIP1:     cmp_expect = local_ip_reg[23:16];
            POS_DIP2:     cmp_expect = local_ip_reg[15:8];
            POS_DIP3:     cmp_expect = local_ip_reg[7:0];
            POS_ICMP_TYP: cmp_expect = ICMP_ECHO_REQ;
            default:      cmp_active = 1'b0;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV: begin
                if (s_fire && !fwd_reg && hdr_pos == POS_LAST && in_header && ok_reg) begin
                    state_next = ST_CKSUM;
                end
            end
            ST_CKSUM: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SEND;
            ST_SEND: begin
                if (hdr_done) begin
                    state_next = ST_RECV;
                end else if (m_fire) begin
                    state_next = ST_FETCH;
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb begin
        s_axis_tready  = (state_reg == ST_RECV) && !out_valid_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = (state_reg == ST_FETCH);
        ram_rd_addr    = reply_addr(k_reg);
        cks_sum        = {1'b0, cks_reg} + {1'b0, CKS_ADJUST};
        pos_next       = pos_reg;
        fwd_next       = fwd_reg;
        ok_next        = ok_reg;
        k_next         = k_reg;
        cks_next       = cks_reg;
        end37_next     = end37_reg;
        out_valid_next = out_valid_reg && !m_fire;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RECV: begin
                if (s_fire) begin
                    if (fwd_reg) begin
                        // Pass the payload through after a reply header.
                        out_valid_next = 1'b1;
                        out_data_next  = s_axis_tdata;
                        out_last_next  = s_axis_tlast;
                    end else if (in_header) begin
                        ram_wr_en = 1'b1;
                        if (hdr_pos == '0) begin
                            ok_next = 1'b1;
                        end else if (cmp_active) begin
                            ok_next = ok_reg && (s_axis_tdata == cmp_expect);
                        end
                        if (hdr_pos == POS_CKS_HI) begin
                            cks_next[15:8] = s_axis_tdata;
                        end
                        if (hdr_pos == POS_CKS_LO) begin
                            cks_next[7:0] = s_axis_tdata;
                            end37_next    = s_axis_tlast;
                        end
                        k_next = '0;
                    end
                    // Frame position, cleared by the end of frame.
                    if (s_axis_tlast) begin
                        pos_next = '0;
                        fwd_next = 1'b0;
                    end else if (pos_reg < POS_W'(MAX_FRAME_BYTES - 1)) begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            ST_CKSUM: begin
                // Ones-complement add with end-around carry.
                cks_next = cks_sum[15:0] + {15'd0, cks_sum[16]};
            end
            ST_LOAD: begin
                out_valid_next = 1'b1;
                out_last_next  = (k_reg == POS_LAST) ? end37_reg : 1'b0;
                case (reply_kind(k_reg))
                    SRC_MAC:    out_data_next = mac_bytes[mac_idx];
                    SRC_ZERO:   out_data_next = ICMP_ECHO_REP;
                    SRC_CKS_HI: out_data_next = cks_reg[15:8];
                    SRC_CKS_LO: out_data_next = cks_reg[7:0];
                    default:    out_data_next = ram_rd_data;
                endcase
            end
            ST_SEND: begin
                if (hdr_done) begin
                    fwd_next = !end37_reg;
                end else if (m_fire) begin
                    k_next = k_reg + HDR_AW'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RECV;
            pos_reg       <= '0;
            fwd_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fwd_reg       <= fwd_next;
            ok_reg        <= ok_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cks_reg      <= cks_next;
        end37_reg    <= end37_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg <= '0;
            local_ip_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_LOCAL_MAC) begin
                local_mac_reg <= cfg_data;
            end else if (cfg_index == CFG_LOCAL_IP) begin
                local_ip_reg <= cfg_data[31:0];
            end
        end
    end

endmodule

// ===== hdl/ierw_checker.sv =====
module ierw_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled result holds its byte and end flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Input is taken only while the output register is empty.
    a_in_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    // A single output register: a completed transfer leaves it empty.
    a_out_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result valid right after a transfer");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind icmp_echo_reply_rewriter ierw_checker u_ierw_checker (.*);
